>>> sv/pipp_pkg.sv
// ----------------------------------------------------------------------------
// pipp_pkg
// Shared types and constants for the point-in-polygon ray-casting block.
// ----------------------------------------------------------------------------
package pipp_pkg;

  localparam int SLOT_BITS  = 6;
  localparam int COUNT_BITS = 7;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  // control into the edge datapath
  typedef struct packed {
    logic init;      // load query point, clear parity
    logic edge_vld;  // one edge presented this cycle
  } edge_ctl_t;

  // status out of the edge datapath
  typedef struct packed {
    logic pend;      // edge still in flight
  } edge_sts_t;

endpackage

>>> sv/pipp_edge_unit.sv
// ----------------------------------------------------------------------------
// pipp_edge_unit
// Pipelined edge test: y ordering and query-y rise, slope operands,
// cross products, parity update. One edge per cycle.
// ----------------------------------------------------------------------------
module pipp_edge_unit #(
  parameter int COORD_BITS = 24,
  parameter int MAX_POINTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pipp_pkg::edge_ctl_t          ctl,
  input  logic signed [COORD_BITS-1:0] init_px,
  input  logic signed [COORD_BITS-1:0] init_py,
  input  logic signed [COORD_BITS-1:0] vtx_a_x,
  input  logic signed [COORD_BITS-1:0] vtx_a_y,
  input  logic signed [COORD_BITS-1:0] vtx_b_x,
  input  logic signed [COORD_BITS-1:0] vtx_b_y,
  output pipp_pkg::edge_sts_t          sts,
  output logic                         parity
);

  localparam int CB = COORD_BITS;
  // query y grows by at most one per edge
  localparam int PW = CB + $clog2(MAX_POINTS) + 1;
  localparam int DW = CB + 1;
  localparam int MW = PW + DW;

  // ---------------- stage A: order endpoints, rise query y
  logic signed [CB-1:0] px_r;
  logic signed [PW-1:0] py_r;
  logic signed [PW-1:0] py_nxt;
  logic signed [PW-1:0] ly_w, uy_w, init_py_w;
  logic signed [CB-1:0] lx, ly, ux, uy;
  logic                 swap, py_hit;

  assign swap = vtx_a_y > vtx_b_y;
  assign lx   = swap ? vtx_b_x : vtx_a_x;
  assign ly   = swap ? vtx_b_y : vtx_a_y;
  assign ux   = swap ? vtx_a_x : vtx_b_x;
  assign uy   = swap ? vtx_a_y : vtx_b_y;

  assign ly_w      = {{(PW-CB){ly[CB-1]}}, ly};
  assign uy_w      = {{(PW-CB){uy[CB-1]}}, uy};
  assign init_py_w = {{(PW-CB){init_py[CB-1]}}, init_py};
  assign py_hit    = (py_r == ly_w) || (py_r == uy_w);
  assign py_nxt    = py_r + $signed({{(PW-1){1'b0}}, py_hit});

  logic                 a_vld_r;
  logic signed [CB-1:0] a_lx_r, a_ly_r, a_ux_r, a_uy_r;
  logic signed [PW-1:0] a_py_r;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      px_r <= init_px;
      py_r <= init_py_w;
    end else if (ctl.edge_vld) begin
      py_r <= py_nxt;
    end
    a_lx_r <= lx;
    a_ly_r <= ly;
    a_ux_r <= ux;
    a_uy_r <= uy;
    a_py_r <= py_nxt;
  end

  // ---------------- stage B: range flags and cross-product operands
  logic signed [PW-1:0] a_ly_w, a_uy_w;
  logic signed [CB-1:0] mn, mx;
  logic                 between, left, mid;
  logic        [PW-1:0] diff_a;
  logic        [DW-1:0] diff_c;
  logic signed [DW-1:0] diff_b, diff_d;
  logic        [DW-1:0] mag_b, mag_d;

  assign a_ly_w  = {{(PW-CB){a_ly_r[CB-1]}}, a_ly_r};
  assign a_uy_w  = {{(PW-CB){a_uy_r[CB-1]}}, a_uy_r};
  assign between = (a_py_r < a_uy_w) && (a_py_r > a_ly_w);
  assign mn      = (a_lx_r < a_ux_r) ? a_lx_r : a_ux_r;
  assign mx      = (a_lx_r < a_ux_r) ? a_ux_r : a_lx_r;
  assign left    = px_r < mn;
  assign mid     = px_r < mx;

  assign diff_a = a_py_r - a_ly_w;
  assign diff_c = {a_uy_r[CB-1], a_uy_r} - {a_ly_r[CB-1], a_ly_r};
  assign diff_b = {px_r[CB-1], px_r} - {a_lx_r[CB-1], a_lx_r};
  assign diff_d = {a_ux_r[CB-1], a_ux_r} - {a_lx_r[CB-1], a_lx_r};
  assign mag_b  = diff_b[DW-1] ? -diff_b : diff_b;
  assign mag_d  = diff_d[DW-1] ? -diff_d : diff_d;

  logic          b_vld_r, b_left_r, b_mid_r, b_dpos_r;
  logic [PW-1:0] b_a_r;
  logic [DW-1:0] b_c_r, b_mb_r, b_md_r;

  always_ff @(posedge clk) begin
    b_left_r <= between && left;
    b_mid_r  <= between && !left && mid;
    b_dpos_r <= !diff_d[DW-1] && (diff_d != '0);
    b_a_r    <= diff_a;
    b_c_r    <= diff_c;
    b_mb_r   <= mag_b;
    b_md_r   <= mag_d;
  end

  // ---------------- stage M: products
  logic          m_vld_r, m_left_r, m_mid_r, m_dpos_r;
  logic [MW-1:0] m_ad_r, m_cb_r;

  always_ff @(posedge clk) begin
    m_left_r <= b_left_r;
    m_mid_r  <= b_mid_r;
    m_dpos_r <= b_dpos_r;
    m_ad_r   <= {{DW{1'b0}}, b_a_r} * {{PW{1'b0}}, b_md_r};
    m_cb_r   <= {{PW{1'b0}}, b_c_r} * {{PW{1'b0}}, b_mb_r};
  end

  // ---------------- stage C: compare and toggle
  logic parity_r;
  logic tog;

  assign tog = m_left_r ||
               (m_mid_r && (m_dpos_r ? (m_ad_r > m_cb_r) : (m_cb_r > m_ad_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      m_vld_r  <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      a_vld_r <= ctl.edge_vld;
      b_vld_r <= a_vld_r;
      m_vld_r <= b_vld_r;
      if (ctl.init) begin
        parity_r <= 1'b0;
      end else if (m_vld_r) begin
        parity_r <= parity_r ^ tog;
      end
    end
  end

  assign sts.pend = a_vld_r || b_vld_r || m_vld_r;
  assign parity   = parity_r;

endmodule

>>> sv/point_in_polygon_test_top.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Ray-casting geofence: vertex loads fill a table, queries walk its edges.
// ----------------------------------------------------------------------------
// Load transaction: written into the vertex memory at accept, no result; loads
//   can follow back to back.
// Query, n = min(point_count, MAX_POINTS) >= 2: busy through the walk and drain after accept,
//   strobe next cycle; no new query is taken until the result, the walk reading one vertex a cycle.
// Query, n < 2: outside strobed in the cycle after accept; busy stays low.
// Sync active-low reset clears control and point_count, not the vertex memory.
module point_in_polygon_test_top #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // query / load channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [pipp_pkg::SLOT_BITS-1:0]      in_vertex_slot,
  input  logic signed [COORD_BITS-1:0]        in_coord_x,
  input  logic signed [COORD_BITS-1:0]        in_coord_y,
  // result channel, receiver cannot stall
  output logic                                out_valid,
  output logic                                out_inside_res,
  // point_count register
  input  logic                                cfg_we,
  input  logic [pipp_pkg::COUNT_BITS-1:0]     cfg_wdata
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_POINTS);      // memory address
  localparam int NW = $clog2(MAX_POINTS + 1);  // point count up to MAX_POINTS

  // ---------------------------------------------------------------- config
  logic [pipp_pkg::COUNT_BITS-1:0] cfg_r;
  logic [NW-1:0]                   n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // counts above the table depth clamp to the depth
  assign n_eff = (32'(cfg_r) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(cfg_r);

  // ---------------------------------------------------------------- accept
  pipp_pkg::state_t state_r, state_nxt;
  logic accept, load_go, qry_go, qry_short;
  logic wr_en;
  logic [AW-1:0] wr_addr;

  assign busy      = (state_r != pipp_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign load_go   = accept && (in_func == pipp_pkg::FUNC_LOAD);
  assign qry_go    = accept && (in_func == pipp_pkg::FUNC_QUERY) && (n_eff >= NW'(2));
  assign qry_short = accept && (in_func == pipp_pkg::FUNC_QUERY) && (n_eff < NW'(2));

  // slots past the table depth are dropped
  assign wr_en   = load_go && (32'(in_vertex_slot) < MAX_POINTS);
  assign wr_addr = AW'(32'(in_vertex_slot));

  // ---------------------------------------------------------------- memory
  // {x, y} per vertex; writes only while idle, and read data is used only by the
  // walk, so a write never collides with a read in use.
  logic [2*CB-1:0] vtx_mem [MAX_POINTS];
  logic [2*CB-1:0] rd_data_r;
  logic [AW-1:0]   rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vtx_mem[wr_addr] <= {in_coord_x, in_coord_y};
    end
    rd_data_r <= vtx_mem[rd_addr];
  end

  // ---------------------------------------------------------------- walker
  logic [NW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [NW-1:0]   n_r;
  logic            rd_en;
  logic            rd_vld_r, rd_first_r;
  logic [2*CB-1:0] prev_r;
  logic            out_vld_r, out_vld_nxt;
  logic            out_ins_r, out_ins_nxt;
  logic            parity;

  pipp_pkg::edge_ctl_t edge_ctl;
  pipp_pkg::edge_sts_t edge_sts;

  assign rd_addr = rd_cnt_r[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    rd_en       = 1'b0;
    rd_cnt_nxt  = rd_cnt_r;
    out_vld_nxt = 1'b0;
    out_ins_nxt = out_ins_r;
    case (state_r)
      pipp_pkg::ST_IDLE: begin
        rd_cnt_nxt = '0;
        if (qry_go) begin
          state_nxt = pipp_pkg::ST_WALK;
        end else if (qry_short) begin
          // no edge to walk: outside
          out_vld_nxt = 1'b1;
          out_ins_nxt = 1'b0;
        end
      end
      pipp_pkg::ST_WALK: begin
        rd_en      = 1'b1;
        rd_cnt_nxt = rd_cnt_r + NW'(1);
        if (rd_cnt_r == n_r - NW'(1)) begin
          state_nxt = pipp_pkg::ST_DRAIN;
        end
      end
      pipp_pkg::ST_DRAIN: begin
        // last read returned and edge pipe empty: parity is final
        if (!rd_vld_r && !edge_sts.pend) begin
          state_nxt   = pipp_pkg::ST_IDLE;
          out_vld_nxt = 1'b1;
          out_ins_nxt = parity;
        end
      end
      default: begin
        state_nxt = pipp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pipp_pkg::ST_IDLE;
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      out_vld_r  <= 1'b0;
      rd_cnt_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= rd_en;
      rd_first_r <= rd_en && (rd_cnt_r == '0);
      out_vld_r  <= out_vld_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (qry_go) begin
      n_r <= n_eff;
    end
    if (rd_vld_r) begin
      prev_r <= rd_data_r;
    end
    out_ins_r <= out_ins_nxt;
  end

  // edge i pairs the previous vertex with the one just read
  assign edge_ctl.init     = qry_go;
  assign edge_ctl.edge_vld = rd_vld_r && !rd_first_r;

  pipp_edge_unit #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (edge_ctl),
    .init_px (in_coord_x),
    .init_py (in_coord_y),
    .vtx_a_x (prev_r[2*CB-1:CB]),
    .vtx_a_y (prev_r[CB-1:0]),
    .vtx_b_x (rd_data_r[2*CB-1:CB]),
    .vtx_b_y (rd_data_r[CB-1:0]),
    .sts     (edge_sts),
    .parity  (parity)
  );

  assign out_valid      = out_vld_r;
  assign out_inside_res = out_ins_r;

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  // no result strobe while edges are still being read
  a_no_result_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pipp_pkg::ST_WALK) |-> !out_vld_r)
    else $error("result strobe during edge walk");

  // walk never reads past the stored point count
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pipp_pkg::ST_WALK) |-> (rd_cnt_r < n_r))
    else $error("vertex read beyond point count");

  // a query with edges to walk starts walking in the next cycle
  a_query_walks: assert property (@(posedge clk) disable iff (!rst_n)
    qry_go |=> (state_r == pipp_pkg::ST_WALK))
    else $error("accepted query did not start walking");
`endif

endmodule
